@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/fcrp_pkg.sv @@
// ----------------------------------------------------------------------------
// fcrp_pkg: flow cache types and constants
// key layout, item structs and the control word broadcast to the cells
// ----------------------------------------------------------------------------
package fcrp_pkg;
	// must be a power of two, the random victim is the low lfsr bits
	localparam int ENTRIES = 128;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int POS_W = 7;
	localparam int ADDR_W = 3;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_RANDOM = 2'd1;
	localparam logic [1:0] POL_LRU = 2'd2;
	localparam logic [1:0] POL_HEAVY = 2'd3;
	localparam logic [1:0] POL_RESET = POL_LRU;

	localparam logic REG_POLICY = 1'b0;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
	} key_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic        heavy_flag;
	} in_item_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] hit_position;
		logic             evicted;
		logic [31:0]      evicted_src_addr;
		logic [31:0]      evicted_dst_addr;
		logic [15:0]      evicted_src_port;
		logic [15:0]      evicted_dst_port;
		logic [7:0]       evicted_protocol;
	} out_item_t;

	typedef struct packed {
		logic             load_en;
		logic [IDX_W-1:0] load_idx;
		logic             shift_en;
		logic [IDX_W-1:0] shift_lim;
	} cell_ctrl_t;
endpackage

@@ rtl/fcrp_cell.sv @@
// ----------------------------------------------------------------------------
// fcrp_cell: one slot of the flow cache
// holds a key and valid bit, compares against the lookup key, and loads
// the key or takes its lower-index neighbor's entry on command
// ----------------------------------------------------------------------------
module fcrp_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [fcrp_pkg::IDX_W-1:0] idx,
	input  fcrp_pkg::key_t         cmp_key,
	input  fcrp_pkg::cell_ctrl_t   ctrl,
	input  fcrp_pkg::key_t         prev_key,
	input  logic                   prev_valid,
	output fcrp_pkg::key_t         key_q,
	output logic                   valid_q,
	output logic                   match_q
);
	import fcrp_pkg::*;

	logic sel_load;
	logic sel_shift;

	assign sel_load = ctrl.load_en && (ctrl.load_idx == idx);
	assign sel_shift = ctrl.shift_en && (idx != '0) && (idx <= ctrl.shift_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			match_q <= valid_q && (key_q == cmp_key);
			if (sel_load) begin
				valid_q <= 1'b1;
			end else if (sel_shift) begin
				valid_q <= prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel_load) begin
			key_q <= cmp_key;
		end else if (sel_shift) begin
			key_q <= prev_key;
		end
	end
endmodule

@@ rtl/flow_cache_replacement_policy.sv @@
// ----------------------------------------------------------------------------
// flow_cache_replacement_policy: fully associative flow cache
// row of key cells with fifo, random, lru and heavy-aware replacement
// ----------------------------------------------------------------------------
// an item holds busy while all cells compare (ST_CMP), then the row updates (ST_UPD)
// result strobe (done) is registered from the update state; no new item is taken while busy
// the compare and update steps plus a pass through idle between items set the rate
// reset empties the cache, policy goes to lru and the lfsr to its seed
// the receiver cannot stall: each done strobe shows for exactly one cycle
module flow_cache_replacement_policy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fcrp_pkg::in_item_t            cmd,
	output logic                          done,
	output fcrp_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcrp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import fcrp_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t           state_q;
	key_t             key_q;
	logic             heavy_q;
	logic [1:0]       policy_q;
	logic [CNT_W-1:0] fill_q;
	logic [15:0]      lfsr_q;
	logic [15:0]      lfsr_nxt;
	cell_ctrl_t       ctrl;
	key_t             cell_key [ENTRIES];
	logic             cell_valid [ENTRIES];
	logic             cell_match [ENTRIES];
	logic             hit;
	logic [IDX_W-1:0] pos;
	logic [IDX_W-1:0] victim;
	logic             full;
	logic             ev;
	key_t             ev_key;
	logic             lfsr_step;
	logic             accept;

	assign pready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign prdata = (paddr[2] == REG_POLICY) ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_POLICY)) begin
			policy_q <= pwdata[1:0];
		end
	end

	// the row of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		key_t prev_key;
		logic prev_valid;
		if (i == 0) begin : g_head
			assign prev_key = '0;
			assign prev_valid = 1'b0;
		end else begin : g_body
			assign prev_key = cell_key[i-1];
			assign prev_valid = cell_valid[i-1];
		end
		fcrp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.cmp_key    (key_q),
			.ctrl       (ctrl),
			.prev_key   (prev_key),
			.prev_valid (prev_valid),
			.key_q      (cell_key[i]),
			.valid_q    (cell_valid[i]),
			.match_q    (cell_match[i])
		);
	end

	// first matching slot
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit = 1'b1;
				pos = IDX_W'(i);
			end
		end
	end

	assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign victim = lfsr_nxt[IDX_W-1:0];
	assign full = (fill_q == CNT_W'(ENTRIES));

	always_comb begin
		ctrl = '0;
		ev = 1'b0;
		ev_key = '0;
		lfsr_step = 1'b0;
		if (state_q == ST_UPD) begin
			if (hit) begin
				if (policy_q == POL_LRU || (policy_q == POL_HEAVY && heavy_q)) begin
					ctrl.shift_en = 1'b1;
					ctrl.shift_lim = pos;
					ctrl.load_en = 1'b1;
				end
			end else if (!full) begin
				ctrl.load_en = 1'b1;
				ctrl.load_idx = fill_q[IDX_W-1:0];
			end else begin
				ev = 1'b1;
				ctrl.load_en = 1'b1;
				if (policy_q == POL_RANDOM) begin
					lfsr_step = 1'b1;
					ctrl.load_idx = victim;
					ev_key = cell_key[victim];
				end else begin
					ev_key = cell_key[ENTRIES-1];
					if (policy_q == POL_HEAVY && !heavy_q) begin
						ctrl.load_idx = IDX_W'(ENTRIES - 1);
					end else begin
						ctrl.shift_en = 1'b1;
						ctrl.shift_lim = IDX_W'(ENTRIES - 1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			lfsr_q <= LFSR_SEED;
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_UPD);
			if (lfsr_step) begin
				lfsr_q <= lfsr_nxt;
			end
			if (state_q == ST_UPD && !hit && !full) begin
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {cmd.src_addr, cmd.dst_addr, cmd.src_port, cmd.dst_port, cmd.protocol};
			heavy_q <= cmd.heavy_flag;
		end
		if (state_q == ST_UPD) begin
			result.hit <= hit;
			result.hit_position <= hit ? POS_W'(pos) : '0;
			result.evicted <= ev;
			result.evicted_src_addr <= ev_key.src_addr;
			result.evicted_dst_addr <= ev_key.dst_addr;
			result.evicted_src_port <= ev_key.src_port;
			result.evicted_dst_port <= ev_key.dst_port;
			result.evicted_protocol <= ev_key.protocol;
		end
	end

	`ASSERT_CLK(a_done_after_upd, done |-> $past(state_q == ST_UPD), "done without update")
	`ASSERT_CLK(a_accept_busy, accept |=> (state_q == ST_CMP), "item not taken")
	`ASSERT_NEVER(a_fill_over, fill_q > CNT_W'(ENTRIES), "fill count overflow")
	`ASSERT_NEVER(a_hit_evict, done && result.hit && result.evicted, "hit with eviction")
endmodule
